### rtl/core/ddc_ci_vcp_reply_checker_top_assert.svh
// Assertion macros for the DDC/CI VCP reply checker top level.
// Needs signals named clock and reset in the including scope.
`ifndef DDC_CI_VCP_REPLY_CHECKER_TOP_ASSERT_SVH
`define DDC_CI_VCP_REPLY_CHECKER_TOP_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define DDCVCP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ddcvcp assertion failed");

// Check that a condition holds at every clock edge out of reset.
`define DDCVCP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("ddcvcp assertion failed");

`endif

### rtl/core/ddcvcp_pkg.sv
// Shared types and constants of the DDC/CI VCP reply checker.
// No dependencies; every module of the block refers to it by scoped names.
package ddcvcp_pkg;

   // Frame layout
   localparam logic [3:0] FRAME_DATA     = 4'd10;  // captured bytes before checksum
   localparam logic [7:0] REPLY_OPCODE   = 8'h02;
   localparam logic [7:0] LENGTH_FLAG    = 8'h80;
   localparam logic [7:0] BODY_LENGTH    = 8'h08;
   localparam logic [7:0] RESULT_NO_ERR  = 8'h00;

   // Configuration register reset values
   localparam logic [7:0] FEATURE_RESET  = 8'h10;
   localparam logic [7:0] ADDRESS_RESET  = 8'h6e;
   localparam logic [7:0] SEED_RESET     = 8'h50;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FEATURE_CODE   = 2'd0,
      CSR_SOURCE_ADDRESS = 2'd1,
      CSR_CHECKSUM_SEED  = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // Result status codes
   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_BUS      = 4'd1,
      ST_CHECKSUM = 4'd2,
      ST_ADDRESS  = 4'd3,
      ST_LENGTH   = 4'd4,
      ST_OPCODE   = 4'd5,
      ST_RESULT   = 4'd6,
      ST_FEATURE  = 4'd7,
      ST_ZERO_MAX = 4'd8
   } status_type;

   typedef struct packed {
      logic [7:0] feature_code;
      logic [7:0] source_address;
      logic [7:0] checksum_seed;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic       bus_error;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] peak_level;
      logic [15:0] live_level;
      logic        max_changed;
   } result_type;

endpackage

### rtl/core/ddcvcp_csr.sv
// Configuration registers of the DDC/CI VCP reply checker.
// Depends on ddcvcp_pkg for the register indexes and reset values.
module ddcvcp_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data,
   output ddcvcp_pkg::cfg_type cfg
);

   ddcvcp_pkg::cfg_type cfg_ff;
   ddcvcp_pkg::cfg_type cfg_in;
   logic                write_en;

   // Always take writes
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (ddcvcp_pkg::csr_index_type'(csr_index))
            ddcvcp_pkg::CSR_FEATURE_CODE:   cfg_in.feature_code   = csr_data;
            ddcvcp_pkg::CSR_SOURCE_ADDRESS: cfg_in.source_address = csr_data;
            ddcvcp_pkg::CSR_CHECKSUM_SEED:  cfg_in.checksum_seed  = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_code   <= ddcvcp_pkg::FEATURE_RESET;
         cfg_ff.source_address <= ddcvcp_pkg::ADDRESS_RESET;
         cfg_ff.checksum_seed  <= ddcvcp_pkg::SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/ddcvcp_in_stage.sv
// Input register of the DDC/CI VCP reply checker: holds one request byte.
// Depends on ddcvcp_pkg for the item type.
module ddcvcp_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ddcvcp_pkg::item_type in_item,
   input  logic                advance,
   output logic                held_valid,
   output ddcvcp_pkg::item_type held_item
);

   logic                 valid_ff;
   logic                 valid_in;
   ddcvcp_pkg::item_type item_ff;
   ddcvcp_pkg::item_type item_in;
   logic                 take;

   // Accept when empty or when the held request moves on this cycle
   assign in_ready = ~valid_ff | advance;
   assign take     = in_valid & in_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

### rtl/core/ddcvcp_frame.sv
// Frame tracker and reply checks of the DDC/CI VCP reply checker.
// Depends on ddcvcp_pkg for types, status codes and frame constants.
module ddcvcp_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ddcvcp_pkg::item_type  item,
   input  ddcvcp_pkg::cfg_type   cfg,
   output logic                  result_valid,
   output ddcvcp_pkg::result_type result,
   output logic [3:0]            position
);

   logic [3:0]  pos_ff,  pos_in;
   logic [7:0]  acc_ff,  acc_in;
   logic [15:0] max_ff,  max_in;
   logic [7:0]  bytes_ff [10];
   logic [7:0]  bytes_in [10];

   logic        restart;
   logic [3:0]  pos_eff;
   logic [7:0]  acc_eff;
   logic [15:0] new_max;
   logic [15:0] new_cur;
   ddcvcp_pkg::status_type check_status;

   // Open a new frame on start, on an idle position or past the end
   assign restart = item.frame_start | (pos_ff == 4'd0) | (pos_ff > ddcvcp_pkg::FRAME_DATA);
   assign pos_eff = restart ? 4'd0 : pos_ff;
   assign acc_eff = restart ? cfg.checksum_seed : acc_ff;

   assign new_max = {bytes_ff[6], bytes_ff[7]};
   assign new_cur = {bytes_ff[8], bytes_ff[9]};

   // Run the checks in priority order on the checksum byte
   always_comb begin
      if (item.rx_byte != acc_eff) begin
         check_status = ddcvcp_pkg::ST_CHECKSUM;
      end else if (bytes_ff[0] != cfg.source_address) begin
         check_status = ddcvcp_pkg::ST_ADDRESS;
      end else if ((bytes_ff[1] & ~ddcvcp_pkg::LENGTH_FLAG) != ddcvcp_pkg::BODY_LENGTH) begin
         check_status = ddcvcp_pkg::ST_LENGTH;
      end else if (bytes_ff[2] != ddcvcp_pkg::REPLY_OPCODE) begin
         check_status = ddcvcp_pkg::ST_OPCODE;
      end else if (bytes_ff[3] != ddcvcp_pkg::RESULT_NO_ERR) begin
         check_status = ddcvcp_pkg::ST_RESULT;
      end else if (bytes_ff[4] != cfg.feature_code) begin
         check_status = ddcvcp_pkg::ST_FEATURE;
      end else if (new_max == 16'd0) begin
         check_status = ddcvcp_pkg::ST_ZERO_MAX;
      end else begin
         check_status = ddcvcp_pkg::ST_OK;
      end
   end

   // Capture, accumulate or finish the frame
   always_comb begin
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      max_in       = max_ff;
      bytes_in     = bytes_ff;
      result_valid = 1'b0;
      result       = '0;
      if (advance) begin
         if (item.bus_error) begin
            pos_in        = 4'd0;
            result_valid  = 1'b1;
            result.status = ddcvcp_pkg::ST_BUS;
         end else if (pos_eff < ddcvcp_pkg::FRAME_DATA) begin
            for (int i = 0; i < 10; i++) begin
               if (pos_eff == 4'(i)) begin
                  bytes_in[i] = item.rx_byte;
               end
            end
            acc_in = acc_eff ^ item.rx_byte;
            pos_in = pos_eff + 4'd1;
         end else begin
            pos_in        = 4'd0;
            result_valid  = 1'b1;
            result.status = check_status;
            if (check_status == ddcvcp_pkg::ST_OK) begin
               result.peak_level  = new_max;
               result.live_level  = new_cur;
               result.max_changed = (max_ff != 16'd0) && (new_max != max_ff);
               max_in             = new_max;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
         acc_ff <= 8'd0;
         max_ff <= 16'd0;
      end else begin
         pos_ff <= pos_in;
         acc_ff <= acc_in;
         max_ff <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   assign position = pos_ff;

endmodule

### rtl/core/ddcvcp_out_stage.sv
// Result register of the DDC/CI VCP reply checker.
// Depends on ddcvcp_pkg for the result type.
module ddcvcp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ddcvcp_pkg::result_type load_result,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ddcvcp_pkg::result_type out_result
);

   logic                   valid_ff;
   logic                   valid_in;
   ddcvcp_pkg::result_type result_ff;
   ddcvcp_pkg::result_type result_in;

   // Load a fresh result, drop the held one once taken
   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = load_result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

### rtl/core/ddc_ci_vcp_reply_checker_top.sv
// Top level of the DDC/CI Get VCP Feature reply checker.
// Uses ddcvcp_pkg, ddcvcp_csr, ddcvcp_in_stage, ddcvcp_frame, ddcvcp_out_stage.
//
//   channel  | dir | handshake          | payload
//   req_     | in  | tvalid / tready    | tdata: rx_byte; tuser: frame_start, bus_error
//   rsp_     | out | tvalid / tready    | tdata: status, peak_level, live_level, max_changed
//   csr_     | in  | valid / ready      | index, data
//
// One request byte per cycle while rsp_ is not stalled; a result passes the input and result registers.
// The frame tracker updates as a byte leaves the input register for the result register.
// Reset is synchronous: it clears both stage valids, the byte position, the checksum and
// the stored maximum and loads the register defaults; captured bytes are not cleared.
// A stalled rsp_ side holds the result; the input register still takes one more byte.
module ddc_ci_vcp_reply_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [0] frame_start, [1] bus_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] status, [19:4] peak_level,
                                    // [35:20] live_level, [36] max_changed, zero above
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   ddcvcp_pkg::cfg_type    cfg;
   ddcvcp_pkg::item_type   req_item;
   ddcvcp_pkg::item_type   held_item;
   ddcvcp_pkg::result_type frame_result;
   ddcvcp_pkg::result_type rsp_result;
   logic                   held_valid;
   logic                   advance;
   logic                   frame_result_valid;
   logic [3:0]             position;
   logic                   rsp_ok;
   logic                   rsp_fields_zero;

   // Unpack the request
   assign req_item.rx_byte     = req_tdata;
   assign req_item.frame_start = req_tuser[0];
   assign req_item.bus_error   = req_tuser[1];

   // Move the held request on when the result register is free or emptying
   assign advance = held_valid & (~rsp_tvalid | rsp_tready);

   ddcvcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ddcvcp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   ddcvcp_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (held_item),
      .cfg          (cfg),
      .result_valid (frame_result_valid),
      .result       (frame_result),
      .position     (position)
   );

   ddcvcp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (frame_result_valid),
      .load_result (frame_result),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (rsp_result)
   );

   // Pack the response
   assign rsp_tdata = {3'b000, rsp_result.max_changed, rsp_result.live_level,
                       rsp_result.peak_level, rsp_result.status};

   // Summarize the held response for the checks below
   assign rsp_ok          = (rsp_result.status == ddcvcp_pkg::ST_OK);
   assign rsp_fields_zero = (rsp_result.peak_level == 16'd0) &&
                            (rsp_result.live_level == 16'd0) && !rsp_result.max_changed;

`include "ddc_ci_vcp_reply_checker_top_assert.svh"

   `DDCVCP_ASSERT_ALWAYS(a_position_range, position <= ddcvcp_pkg::FRAME_DATA)
   `DDCVCP_ASSERT_IMPLY(a_ok_has_max, rsp_tvalid && rsp_ok, rsp_result.peak_level != 16'd0)
   `DDCVCP_ASSERT_IMPLY(a_fail_zero_fields, rsp_tvalid && !rsp_ok, rsp_fields_zero)
   `DDCVCP_ASSERT_IMPLY(a_result_ends_frame, frame_result_valid, ##1 position == 4'd0)

endmodule

### bench/tb_ddc_ci_vcp_reply_checker_top.sv
// Testbench for the DDC/CI Get VCP reply checker top level: directed frames, then random
// reply frames under several register settings, checked against an in-bench frame tracker.
// Depends on ddcvcp_pkg and ddc_ci_vcp_reply_checker_top.
module tb_ddc_ci_vcp_reply_checker_top;

   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PLAN_ROWS    = 26;
   localparam int PRINT_CAP    = 50;

   // One directed step: a request and, where obvious, its result typed in
   typedef struct packed {
      ddcvcp_pkg::item_type   stim;
      logic                   typed;
      ddcvcp_pkg::result_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic [1:0]  req_tuser;    // [0] frame_start, [1] bus_error
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [3:0] status, [19:4] peak_level, [35:20] live_level,
                              // [36] max_changed, zero above
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [7:0]  csr_data;

   // Frame tracker state kept by the bench
   ddcvcp_pkg::cfg_type    shadow_cfg;
   logic [3:0]             frame_pos;
   logic [7:0]             running_xor;
   logic [7:0]             captured [0:9];
   logic [15:0]            stored_max;
   ddcvcp_pkg::result_type pending_results [$];

   plan_row_type directed_plan [0:PLAN_ROWS-1];

   bit  no_idle;
   bit  long_hold_request;
   int  cycle_count;
   int  mismatch_count;
   int  items_sent;
   int  frames_sent;
   int  results_checked;
   int  ok_replies;
   int  changes_seen;

   ddc_ci_vcp_reply_checker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Pick an idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the frame tracker by one request byte; return 1 when it yields a result
   function automatic bit track_reply_byte(input ddcvcp_pkg::item_type it,
                                           output ddcvcp_pkg::result_type res);
      logic [15:0] level_max;
      res = '0;
      if (it.bus_error) begin
         frame_pos = 4'd0;
         res.status = ddcvcp_pkg::ST_BUS;
         return 1'b1;
      end
      if (it.frame_start || frame_pos == 4'd0 || frame_pos > ddcvcp_pkg::FRAME_DATA) begin
         frame_pos   = 4'd0;
         running_xor = shadow_cfg.checksum_seed;
      end
      if (frame_pos < ddcvcp_pkg::FRAME_DATA) begin
         captured[frame_pos] = it.rx_byte;
         running_xor ^= it.rx_byte;
         frame_pos++;
         return 1'b0;
      end
      // Checksum byte: grade the frame in priority order
      frame_pos = 4'd0;
      if (it.rx_byte != running_xor)
         res.status = ddcvcp_pkg::ST_CHECKSUM;
      else if (captured[0] != shadow_cfg.source_address)
         res.status = ddcvcp_pkg::ST_ADDRESS;
      else if ((captured[1] & ~ddcvcp_pkg::LENGTH_FLAG) != ddcvcp_pkg::BODY_LENGTH)
         res.status = ddcvcp_pkg::ST_LENGTH;
      else if (captured[2] != ddcvcp_pkg::REPLY_OPCODE)
         res.status = ddcvcp_pkg::ST_OPCODE;
      else if (captured[3] != ddcvcp_pkg::RESULT_NO_ERR)
         res.status = ddcvcp_pkg::ST_RESULT;
      else if (captured[4] != shadow_cfg.feature_code)
         res.status = ddcvcp_pkg::ST_FEATURE;
      else if (captured[6] == 8'h00 && captured[7] == 8'h00)
         res.status = ddcvcp_pkg::ST_ZERO_MAX;
      else begin
         level_max       = {captured[6], captured[7]};
         res.status      = ddcvcp_pkg::ST_OK;
         res.peak_level  = level_max;
         res.live_level  = {captured[8], captured[9]};
         res.max_changed = (stored_max != 16'd0 && level_max != stored_max);
         stored_max      = level_max;
      end
      return 1'b1;
   endfunction

   // Offer one request, wait for it to be taken, then log the expected result it yields, if any
   task automatic send_request(input ddcvcp_pkg::item_type it, input logic typed,
                               input ddcvcp_pkg::result_type typed_result);
      int gap;
      ddcvcp_pkg::result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.rx_byte;
      req_tuser  <= {it.bus_error, it.frame_start};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (track_reply_byte(it, predicted))
         pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
   endtask

   // Build one reply frame for the current registers, maybe flawed, and send it
   task automatic send_reply_frame();
      logic [7:0] frame [0:10];
      logic [7:0] sum;
      int flaw;
      int last;
      int k;
      ddcvcp_pkg::item_type it;
      flaw = $urandom_range(0, 19);
      last = 10;
      frame[0] = shadow_cfg.source_address;
      frame[1] = ddcvcp_pkg::BODY_LENGTH |
                 ($urandom_range(0, 1) ? ddcvcp_pkg::LENGTH_FLAG : 8'h00);
      frame[2] = ddcvcp_pkg::REPLY_OPCODE;
      frame[3] = ddcvcp_pkg::RESULT_NO_ERR;
      frame[4] = shadow_cfg.feature_code;
      for (k = 5; k < 10; k++) frame[k] = 8'($urandom);
      // reuse the stored maximum now and then so both change outcomes show up
      if ($urandom_range(0, 3) == 0) {frame[6], frame[7]} = stored_max;
      case (flaw)
         1: frame[0] ^= 8'($urandom_range(1, 255));
         2: frame[1] ^= {1'b0, 7'($urandom_range(1, 127))};
         3: frame[2] ^= 8'($urandom_range(1, 255));
         4: frame[3] = 8'($urandom_range(1, 255));
         5: frame[4] ^= 8'($urandom_range(1, 255));
         6: begin
            frame[6] = 8'h00;
            frame[7] = 8'h00;
         end
         7: frame[$urandom_range(6, 7)] = 8'h00;
         default: ;
      endcase
      sum = shadow_cfg.checksum_seed;
      for (k = 0; k < 10; k++) sum ^= frame[k];
      frame[10] = sum;
      if (flaw == 8 || $urandom_range(0, 15) == 0) frame[10] ^= 8'($urandom_range(1, 255));
      // cut the frame short, by a bus failure or by simply stopping
      if (flaw == 9 || flaw == 10) last = $urandom_range(0, 10);
      for (k = 0; k <= last; k++) begin
         it.rx_byte     = frame[k];
         it.frame_start = (k == 0) ? (flaw != 11) : 1'b0;
         it.bus_error   = (flaw == 9 && k == last);
         if (it.bus_error) begin
            it.rx_byte     = 8'($urandom);
            it.frame_start = 1'($urandom_range(0, 1));
         end
         send_request(it, 1'b0, '0);
      end
      frames_sent++;
   endtask

   // Hold the sender until every result is back and the pipeline is empty
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input ddcvcp_pkg::csr_index_type idx,
                                 input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ddcvcp_pkg::CSR_FEATURE_CODE:   shadow_cfg.feature_code   = value;
         ddcvcp_pkg::CSR_SOURCE_ADDRESS: shadow_cfg.source_address = value;
         ddcvcp_pkg::CSR_CHECKSUM_SEED:  shadow_cfg.checksum_seed  = value;
         default: ;
      endcase
   endtask

   // Drain results, compare with the oldest expectation, and toggle rsp_tready
   initial begin : result_monitor
      int stall_left;
      ddcvcp_pkg::result_type got;
      ddcvcp_pkg::result_type want;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status      = ddcvcp_pkg::status_type'(rsp_tdata[3:0]);
            got.peak_level  = rsp_tdata[19:4];
            got.live_level  = rsp_tdata[35:20];
            got.max_changed = rsp_tdata[36];
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_CAP)
                  $display("%0t: unexpected result status=%0d max=%h cur=%h chg=%0b",
                           $time, got.status, got.peak_level, got.live_level,
                           got.max_changed);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (want.status == ddcvcp_pkg::ST_OK) ok_replies++;
               if (want.max_changed) changes_seen++;
               if (got.status != want.status || got.peak_level != want.peak_level ||
                   got.live_level != want.live_level ||
                   got.max_changed != want.max_changed) begin
                  mismatch_count++;
                  if (mismatch_count <= PRINT_CAP)
                     $display("%0t: mismatch expected status=%0d max=%h cur=%h chg=%0b, %s",
                              $time, want.status, want.peak_level, want.live_level,
                              want.max_changed,
                              $sformatf("actual status=%0d max=%h cur=%h chg=%0b",
                                        got.status, got.peak_level, got.live_level,
                                        got.max_changed));
               end
            end
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Reset, directed frames, then random phases under changing registers
   initial begin : stimulus
      ddcvcp_pkg::item_type noise;
      int phase_start;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 2'b00;
      csr_valid  <= 1'b0;
      csr_index  <= ddcvcp_pkg::CSR_FEATURE_CODE;
      csr_data   <= 8'h00;
      shadow_cfg  = '{ddcvcp_pkg::FEATURE_RESET, ddcvcp_pkg::ADDRESS_RESET,
                      ddcvcp_pkg::SEED_RESET};
      frame_pos   = 4'd0;
      running_xor = 8'h00;
      stored_max  = 16'd0;
      no_idle     = 1'b0;

      // good reply, bus failure mid-frame, byte with no frame open, restart into a full frame
      directed_plan = '{
         '{'{8'h6e, 1'b1, 1'b0}, 1'b0, '0},
         '{'{8'h88, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h02, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h10, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h64, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h32, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hf2, 1'b0, 1'b0}, 1'b1, '{ddcvcp_pkg::ST_OK, 16'h0064, 16'h0032, 1'b0}},
         '{'{8'h6e, 1'b1, 1'b0}, 1'b0, '0},
         '{'{8'h88, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hff, 1'b1, 1'b1}, 1'b1, '{ddcvcp_pkg::ST_BUS, 16'h0000, 16'h0000, 1'b0}},
         '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h6e, 1'b1, 1'b0}, 1'b0, '0},
         '{'{8'h08, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h02, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'h10, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
         '{'{8'hdb, 1'b0, 1'b0}, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PLAN_ROWS; r++)
         send_request(directed_plan[r].stim, directed_plan[r].typed, directed_plan[r].want);

      for (int phase = 0; phase < PHASES; phase++) begin
         // reprogram only with the pipeline empty
         if (phase > 0) begin
            drain_pipeline();
            case (phase)
               1: begin
                  write_register(ddcvcp_pkg::CSR_FEATURE_CODE, 8'h00);
                  write_register(ddcvcp_pkg::CSR_SOURCE_ADDRESS, 8'h00);
                  write_register(ddcvcp_pkg::CSR_CHECKSUM_SEED, 8'h00);
               end
               2: begin
                  write_register(ddcvcp_pkg::CSR_FEATURE_CODE, 8'hff);
                  write_register(ddcvcp_pkg::CSR_SOURCE_ADDRESS, 8'hff);
                  write_register(ddcvcp_pkg::CSR_CHECKSUM_SEED, 8'hff);
               end
               default: begin
                  write_register(ddcvcp_pkg::CSR_CHECKSUM_SEED, 8'($urandom));
                  write_register(ddcvcp_pkg::CSR_FEATURE_CODE, 8'($urandom));
                  write_register(ddcvcp_pkg::CSR_SOURCE_ADDRESS, 8'($urandom));
               end
            endcase
            if (phase == 4) write_register(ddcvcp_pkg::CSR_UNUSED, 8'($urandom));
         end
         no_idle = (phase == 2 || phase == 5);
         // stall the result side for a long stretch while requests keep coming
         if (phase == 3) long_hold_request = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 7) == 0) begin
               noise.rx_byte     = 8'($urandom);
               noise.frame_start = 1'($urandom_range(0, 1));
               noise.bus_error   = ($urandom_range(0, 3) == 0);
               send_request(noise, 1'b0, '0);
            end else begin
               send_reply_frame();
            end
         end
      end

      drain_pipeline();
      $display("Sent %0d request bytes (%0d random frames) over %0d register settings.",
               items_sent, frames_sent, PHASES);
      $display("Checked %0d results: %0d good replies, %0d with a changed maximum.",
               results_checked, ok_replies, changes_seen);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
